/* rtl/core/vpom_pkg.sv */
// Shared types and constants for the vertex plane outcode mask block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vpom_pkg;

  // Width of the outcode mask; plane bits past this are dropped.
  localparam int MASK_W = 8;
  // Default table depth.
  localparam int MAX_PLANES_DEF = 8;

  localparam int COUNT_W = 4;
  localparam int EPS_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 16;

  // Item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PLANE_COUNT = 1'b0;
  localparam logic CFG_EPSILON     = 1'b1;

  // Group status codes.
  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;

  // One item as it travels down the cell chain.
  typedef struct packed {
    logic                vld;
    logic                op;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  nx;
    logic [COORD_W-1:0]  ny;
    logic [COORD_W-1:0]  nz;
    logic [COORD_W-1:0]  offset;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  pz;
    logic                last;
    logic [MASK_W-1:0]   mask;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/vertex_plane_outcode_mask.sv */
// Top level of the vertex plane outcode mask block: stream ports, config
// registers, the chain of plane cells and the group tail. Uses vpom_pkg,
// vpom_cell and vpom_group.
//
//  Port group   Dir  Carries
//  s_*          in   load-plane and test-vertex beats (tuser = opcode, tlast = last vertex)
//  m_*          out  one result beat per test vertex (tlast = group done)
//  cfg_*        in   register writes: 0 plane_count, 1 epsilon
//
// One beat enters per cycle while no stalled result holds the chain; each result
// passes the three register stages of each plane cell in the chain, then the group output register.
// Load beats travel the same chain, so each vertex sees the planes loaded before it.
// A stalled result freezes the whole chain and s_tready falls with it.
// Reset clears the valid bits and config registers and resets the running masks; plane storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module vertex_plane_outcode_mask
  import vpom_pkg::*;
#(
  parameter int MAX_PLANES = MAX_PLANES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // plane_index[2:0], normal_x[34:3], normal_y[66:35], normal_z[98:67],
  // plane_offset[130:99], point_x[162:131], point_y[194:163], point_z[226:195], zero fill
  input  wire logic [231:0] s_tdata,
  // opcode[0]
  input  wire logic         s_tuser,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // point_mask[7:0], group_status[9:8], zero fill
  output logic [15:0]       m_tdata,
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Plane slots past the mask width can never set a bit, so no cell is built.
  localparam int NUM_CELLS = (MAX_PLANES < MASK_W) ? MAX_PLANES : MASK_W;

  logic [COUNT_W-1:0] plane_count;
  logic [EPS_W-1:0]   epsilon;
  logic               en;
  item_t              chain [NUM_CELLS+1];
  logic [MASK_W-1:0]  out_mask;
  logic [1:0]         out_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
      epsilon     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PLANE_COUNT: plane_count <= cfg_wdata[COUNT_W-1:0];
        CFG_EPSILON:     epsilon     <= cfg_wdata[EPS_W-1:0];
        default:         plane_count <= plane_count;
      endcase
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Unpack the input beat at the head of the chain.
  always_comb begin
    chain[0].vld    = s_tvalid;
    chain[0].op     = s_tuser;
    chain[0].slot   = s_tdata[2:0];
    chain[0].nx     = s_tdata[34:3];
    chain[0].ny     = s_tdata[66:35];
    chain[0].nz     = s_tdata[98:67];
    chain[0].offset = s_tdata[130:99];
    chain[0].px     = s_tdata[162:131];
    chain[0].py     = s_tdata[194:163];
    chain[0].pz     = s_tdata[226:195];
    chain[0].last   = s_tlast;
    chain[0].mask   = '0;
  end

  // Row of plane cells, one per table slot.
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    vpom_cell #(
      .CELL_INDEX(j)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .plane_count(plane_count),
      .epsilon    (epsilon),
      .item_in    (chain[j]),
      .item_out   (chain[j+1])
    );
  end

  // Group masks and output register.
  vpom_group u_group (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_in   (chain[NUM_CELLS]),
    .out_valid (m_tvalid),
    .out_mask  (out_mask),
    .out_done  (m_tlast),
    .out_status(out_status)
  );

  assign m_tdata = {6'b0, out_status, out_mask};

endmodule

`default_nettype wire

/* rtl/core/vpom_cell.sv */
// One plane cell: holds one table plane and tests each passing vertex against it.
// Three register stages; depends on vpom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpom_cell
  import vpom_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [COUNT_W-1:0] plane_count,
  input  wire logic [EPS_W-1:0]   epsilon,
  input  wire item_t              item_in,
  output item_t                   item_out
);

  localparam logic [SLOT_W-1:0]  SLOT  = CELL_INDEX[SLOT_W-1:0];
  localparam logic [COUNT_W-1:0] SLOT4 = CELL_INDEX[COUNT_W-1:0];

  // Plane held by this cell.
  logic [COORD_W-1:0] nx_r;
  logic [COORD_W-1:0] ny_r;
  logic [COORD_W-1:0] nz_r;
  logic [COORD_W-1:0] d_r;

  // Stage registers.
  item_t              s1;
  item_t              s2;
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_y;
  logic signed [63:0] prod_z;
  logic signed [32:0] d_eps;
  logic signed [64:0] sum_a;
  logic signed [64:0] sum_b;

  logic signed [65:0] total;
  logic               hit;
  logic [MASK_W-1:0]  hit_vec;

  // Plane load happens when a load beat for this slot enters the cell.
  always_ff @(posedge clk) begin
    if (en && item_in.vld && item_in.op == OP_LOAD && item_in.slot == SLOT) begin
      nx_r <= item_in.nx;
      ny_r <= item_in.ny;
      nz_r <= item_in.nz;
      d_r  <= item_in.offset;
    end
  end

  // Final sum is exact; the vertex is outside when it is strictly positive.
  always_comb begin
    total   = {sum_a[64], sum_a} + {sum_b[64], sum_b};
    hit     = (s2.op == OP_TEST) && (plane_count > SLOT4) && !total[65] && (|total);
    hit_vec = '0;
    hit_vec[SLOT] = hit;
  end

  // Stage 1 multiplies, stage 2 forms two partial sums, stage 3 sets the bit.
  always_ff @(posedge clk) begin
    // Valid bits of the three stages.
    if (rst) begin
      s1.vld       <= 1'b0;
      s2.vld       <= 1'b0;
      item_out.vld <= 1'b0;
    end else if (en) begin
      s1.vld       <= item_in.vld;
      s2.vld       <= s1.vld;
      item_out.vld <= s2.vld;
    end

    if (en) begin
      s1.op     <= item_in.op;
      s1.slot   <= item_in.slot;
      s1.nx     <= item_in.nx;
      s1.ny     <= item_in.ny;
      s1.nz     <= item_in.nz;
      s1.offset <= item_in.offset;
      s1.px     <= item_in.px;
      s1.py     <= item_in.py;
      s1.pz     <= item_in.pz;
      s1.last   <= item_in.last;
      s1.mask   <= item_in.mask;
      prod_x    <= $signed(item_in.px) * $signed(nx_r);
      prod_y    <= $signed(item_in.py) * $signed(ny_r);
      prod_z    <= $signed(item_in.pz) * $signed(nz_r);
      d_eps     <= $signed({d_r[COORD_W-1], d_r}) + $signed({17'b0, epsilon});

      s2.op     <= s1.op;
      s2.slot   <= s1.slot;
      s2.nx     <= s1.nx;
      s2.ny     <= s1.ny;
      s2.nz     <= s1.nz;
      s2.offset <= s1.offset;
      s2.px     <= s1.px;
      s2.py     <= s1.py;
      s2.pz     <= s1.pz;
      s2.last   <= s1.last;
      s2.mask   <= s1.mask;
      sum_a     <= {prod_x[63], prod_x} + {prod_y[63], prod_y};
      sum_b     <= {prod_z[63], prod_z} + {{16{d_eps[32]}}, d_eps, 16'b0};

      item_out.op     <= s2.op;
      item_out.slot   <= s2.slot;
      item_out.nx     <= s2.nx;
      item_out.ny     <= s2.ny;
      item_out.nz     <= s2.nz;
      item_out.offset <= s2.offset;
      item_out.px     <= s2.px;
      item_out.py     <= s2.py;
      item_out.pz     <= s2.pz;
      item_out.last   <= s2.last;
      item_out.mask   <= s2.mask | hit_vec;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpom_group.sv */
// Group tail: keeps the running OR and AND masks and holds the output register.
// Takes beats from the last plane cell; depends on vpom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpom_group
  import vpom_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire item_t       item_in,
  output logic             out_valid,
  output logic [MASK_W-1:0] out_mask,
  output logic             out_done,
  output logic [1:0]       out_status
);

  logic [MASK_W-1:0] or_acc;
  logic [MASK_W-1:0] and_acc;
  logic [MASK_W-1:0] or_next;
  logic [MASK_W-1:0] and_next;
  logic [1:0]        status_next;
  logic              is_test;

  // Fold the vertex mask in and grade the group on its last vertex.
  always_comb begin
    is_test  = item_in.vld && (item_in.op == OP_TEST);
    or_next  = or_acc | item_in.mask;
    and_next = and_acc & item_in.mask;
    if (!item_in.last) begin
      status_next = ST_INSIDE;
    end else if (and_next != '0) begin
      status_next = ST_OUTSIDE;
    end else if (or_next == '0) begin
      status_next = ST_INSIDE;
    end else begin
      status_next = ST_OVERLAP;
    end
  end

  // Control state: accumulators and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      or_acc    <= '0;
      and_acc   <= '1;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= is_test;
      if (is_test) begin
        if (item_in.last) begin
          or_acc  <= '0;
          and_acc <= '1;
        end else begin
          or_acc  <= or_next;
          and_acc <= and_next;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (en && is_test) begin
      out_mask   <= item_in.mask;
      out_done   <= item_in.last;
      out_status <= status_next;
    end
  end

endmodule

`default_nettype wire
